// File: design/osfc_pkg.sv
// Package of the observer state feedback controller: control types, operand
// source codes, the multiply-accumulate term program and its coefficient ROM.
// No dependencies.
`timescale 1ns / 1ps

package osfc_pkg;

   localparam int SIGNAL_WIDTH_DEF   = 32;
   localparam int COEF_FRAC_BITS_DEF = 24;
   localparam int N_TERMS            = 60;
   localparam int N_ROWS             = 8;
   localparam int CHUNK_BITS         = 32;
   localparam logic [63:0] DEC_SCALE = 64'd10000000000;

   typedef enum logic [4:0] {
      SRC_EST_POS,
      SRC_EST_VEL,
      SRC_EST_PITCH,
      SRC_EST_PRATE,
      SRC_EST_HEAD,
      SRC_EST_HRATE,
      SRC_LAST_LEFT,
      SRC_LAST_RIGHT,
      SRC_MEAS_DIST,
      SRC_MEAS_PITCH,
      SRC_MEAS_HEAD,
      SRC_NEW_POS,
      SRC_NEW_VEL,
      SRC_NEW_PITCH,
      SRC_NEW_PRATE,
      SRC_NEW_HEAD,
      SRC_NEW_HRATE,
      SRC_INT_POS,
      SRC_INT_PITCH,
      SRC_INT_HEAD
   } src_type;

   typedef struct packed {
      src_type            src;
      logic               last;
      logic signed [63:0] dec;
   } term_type;

   typedef struct packed {
      logic issue;
      logic clear;
      logic top;
   } mac_ctrl_type;

   typedef struct packed {
      logic       load;
      logic       wr_en;
      logic [2:0] wr_row;
      logic       commit;
   } regs_ctrl_type;

   typedef logic signed [63:0] coef_rom_type [N_TERMS];

   // coefficients in units of 1e-10; rows 0..5 observer, 6 left, 7 right
   localparam term_type TERMS [N_TERMS] = '{
      '{SRC_EST_POS,    1'b0,  64'sd9846000000},
      '{SRC_EST_VEL,    1'b0,  64'sd1000000},
      '{SRC_EST_PITCH,  1'b0, -64'sd72000000},
      '{SRC_EST_PRATE,  1'b0, -64'sd36550},
      '{SRC_LAST_LEFT,  1'b0,  64'sd522360},
      '{SRC_LAST_RIGHT, 1'b0,  64'sd522360},
      '{SRC_MEAS_DIST,  1'b0,  64'sd154000000},
      '{SRC_MEAS_PITCH, 1'b1,  64'sd72000000},
      '{SRC_EST_POS,    1'b0, -64'sd951000000},
      '{SRC_EST_VEL,    1'b0,  64'sd10000000000},
      '{SRC_EST_PITCH,  1'b0, -64'sd4477000000},
      '{SRC_EST_PRATE,  1'b0,  64'sd2000000},
      '{SRC_LAST_LEFT,  1'b0,  64'sd1085000000},
      '{SRC_LAST_RIGHT, 1'b0,  64'sd1085000000},
      '{SRC_MEAS_DIST,  1'b0,  64'sd950000000},
      '{SRC_MEAS_PITCH, 1'b1,  64'sd4366000000},
      '{SRC_EST_POS,    1'b0, -64'sd73000000},
      '{SRC_EST_VEL,    1'b0, -64'sd36676},
      '{SRC_EST_PITCH,  1'b0,  64'sd8833000000},
      '{SRC_EST_PRATE,  1'b0,  64'sd9000000},
      '{SRC_LAST_LEFT,  1'b0,  64'sd7000000},
      '{SRC_LAST_RIGHT, 1'b0,  64'sd7000000},
      '{SRC_MEAS_DIST,  1'b0,  64'sd73000000},
      '{SRC_MEAS_PITCH, 1'b1,  64'sd1170000000},
      '{SRC_EST_POS,    1'b0, -64'sd5260000000},
      '{SRC_EST_VEL,    1'b0, -64'sd3000000},
      '{SRC_EST_PITCH,  1'b0, -64'sd62310000000},
      '{SRC_EST_PRATE,  1'b0,  64'sd9968000000},
      '{SRC_LAST_LEFT,  1'b0,  64'sd14780000000},
      '{SRC_LAST_RIGHT, 1'b0,  64'sd14780000000},
      '{SRC_MEAS_DIST,  1'b0,  64'sd5260000000},
      '{SRC_MEAS_PITCH, 1'b1,  64'sd68643000000},
      '{SRC_EST_HEAD,   1'b0,  64'sd9146000000},
      '{SRC_EST_HRATE,  1'b0,  64'sd10000000},
      '{SRC_LAST_LEFT,  1'b0, -64'sd4000000},
      '{SRC_LAST_RIGHT, 1'b0,  64'sd4000000},
      '{SRC_MEAS_HEAD,  1'b1,  64'sd854000000},
      '{SRC_EST_HEAD,   1'b0, -64'sd36000000000},
      '{SRC_EST_HRATE,  1'b0,  64'sd9981000000},
      '{SRC_LAST_LEFT,  1'b0, -64'sd8406000000},
      '{SRC_LAST_RIGHT, 1'b0,  64'sd8406000000},
      '{SRC_MEAS_HEAD,  1'b1,  64'sd36000000000},
      '{SRC_NEW_POS,    1'b0,  64'sd15280000000},
      '{SRC_NEW_VEL,    1'b0,  64'sd3149000000},
      '{SRC_NEW_PITCH,  1'b0,  64'sd13802000000},
      '{SRC_NEW_PRATE,  1'b0, -64'sd521000000},
      '{SRC_NEW_HEAD,   1'b0,  64'sd855000000},
      '{SRC_NEW_HRATE,  1'b0,  64'sd95000000},
      '{SRC_INT_POS,    1'b0,  64'sd423170000},
      '{SRC_INT_PITCH,  1'b0, -64'sd196700000},
      '{SRC_INT_HEAD,   1'b1,  64'sd40450000},
      '{SRC_NEW_POS,    1'b0,  64'sd15280000000},
      '{SRC_NEW_VEL,    1'b0,  64'sd3149000000},
      '{SRC_NEW_PITCH,  1'b0,  64'sd13802000000},
      '{SRC_NEW_PRATE,  1'b0, -64'sd521000000},
      '{SRC_NEW_HEAD,   1'b0, -64'sd855000000},
      '{SRC_NEW_HRATE,  1'b0, -64'sd95000000},
      '{SRC_INT_POS,    1'b0,  64'sd423170000},
      '{SRC_INT_PITCH,  1'b0, -64'sd196700000},
      '{SRC_INT_HEAD,   1'b1, -64'sd40450000}
   };

   function automatic int op_width(input int sw);
      return (sw > 32) ? sw : 32;
   endfunction

   function automatic int n_chunks(input int frac);
      return (frac + 8 + CHUNK_BITS - 1) / CHUNK_BITS;
   endfunction

   // round to nearest, ties away from zero
   function automatic coef_rom_type build_coefs(input int frac);
      coef_rom_type rom;
      logic [63:0]  m;
      logic [63:0]  q;
      logic [63:0]  r;
      logic [63:0]  c;
      for (int i = 0; i < N_TERMS; i++) begin
         m = TERMS[i].dec[63] ? 64'(-TERMS[i].dec) : 64'(TERMS[i].dec);
         q = m / DEC_SCALE;
         r = m % DEC_SCALE;
         c = (q << frac) + ((r << frac) + DEC_SCALE / 2) / DEC_SCALE;
         rom[i] = TERMS[i].dec[63] ? -$signed(c) : $signed(c);
      end
      return rom;
   endfunction

endpackage

// File: design/osfc_req_if.sv
// Measurement channel of the observer state feedback controller.
// No dependencies.
`timescale 1ns / 1ps

interface osfc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] travelled_distance;
   logic signed [31:0] pitch_angle;
   logic signed [31:0] heading_angle;

   modport source (output valid, output travelled_distance, output pitch_angle,
                   output heading_angle, input ready);
   modport sink   (input valid, input travelled_distance, input pitch_angle,
                   input heading_angle, output ready);
endinterface

// File: design/osfc_rsp_if.sv
// Torque command channel of the observer state feedback controller.
// No dependencies.
`timescale 1ns / 1ps

interface osfc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_torque;
   logic signed [31:0] right_torque;
   logic               saturated;

   modport source (output valid, output left_torque, output right_torque,
                   output saturated, input ready);
   modport sink   (input valid, input left_torque, input right_torque,
                   input saturated, output ready);
endinterface

// File: design/observer_state_feedback_controller_core.sv
// Top level of the observer state feedback controller: sequencer over the
// term program, shared MAC, state file and result register.
// Depends on osfc_pkg, osfc_req_if, osfc_rsp_if, osfc_mac, osfc_regs.
//
//   channel   direction  word contents
//   req_chan  in         travelled_distance, pitch_angle, heading_angle
//   rsp_chan  out        left_torque, right_torque, saturated
//
// A word runs from accept to the next ready as the single multiplier walks the
// 60 terms, NCH chunks per term, NCH being the number of 32-bit coefficient
// chunks (1 up to 24 fraction bits, 2 up to 56, and so on). Each of the 8 sums
// ends in a pipeline drain state and a write-back state.
// Reset (synchronous) zeroes all estimates, integrators and last torques.
// A result waits in its register while the next word runs; a stalled result
// only holds the final write-back.
`timescale 1ns / 1ps

module observer_state_feedback_controller_core #(
   parameter int SIGNAL_WIDTH   = osfc_pkg::SIGNAL_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = osfc_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   osfc_req_if.sink   req_chan,
   osfc_rsp_if.source rsp_chan
);

   localparam int OPW = osfc_pkg::op_width(SIGNAL_WIDTH);
   localparam int NCH = osfc_pkg::n_chunks(COEF_FRAC_BITS);
   localparam int CPW = osfc_pkg::CHUNK_BITS * NCH + 1;
   localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PCW = $clog2(osfc_pkg::N_TERMS);
   localparam osfc_pkg::coef_rom_type COEFS = osfc_pkg::build_coefs(COEF_FRAC_BITS);
   localparam logic signed [OPW-1:0] MAX32 =
      $signed({{(OPW - 31){1'b0}}, {31{1'b1}}});

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_FLUSH,
      S_FIN,
      S_OUT
   } state_type;

   state_type                     state_ff;
   logic [PCW-1:0]                pc_ff;
   logic [KW-1:0]                 k_ff;
   logic [2:0]                    row_ff;
   logic                          sat_ff;
   logic                          rsp_valid_ff;
   logic signed [31:0]            left_ff;
   logic signed [31:0]            right_ff;
   logic                          rsp_sat_ff;

   osfc_pkg::mac_ctrl_type        mac_ctrl;
   osfc_pkg::regs_ctrl_type       regs_ctrl;
   logic signed [CPW-1:0]         coef;
   logic signed [OPW-1:0]         operand;
   logic signed [SIGNAL_WIDTH-1:0] mac_result;
   logic                          mac_sat;
   logic                          int_sat;
   logic signed [SIGNAL_WIDTH-1:0] tq_left;
   logic signed [SIGNAL_WIDTH-1:0] tq_right;
   logic                          accept;
   logic                          out_free;
   logic                          chunk_top;
   logic signed [OPW-1:0]         left_ext;
   logic signed [OPW-1:0]         right_ext;
   logic signed [31:0]            left_out;
   logic signed [31:0]            right_out;
   logic                          left_clip;
   logic                          right_clip;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign chunk_top = (k_ff == KW'(NCH - 1));
   assign coef      = CPW'(COEFS[pc_ff]);

   assign mac_ctrl.issue = (state_ff == S_MUL);
   assign mac_ctrl.clear = (state_ff == S_FIN);
   assign mac_ctrl.top   = chunk_top;

   assign regs_ctrl.load   = accept;
   assign regs_ctrl.wr_en  = (state_ff == S_FIN);
   assign regs_ctrl.wr_row = row_ff;
   assign regs_ctrl.commit = (state_ff == S_OUT) && out_free;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_torque  = left_ff;
   assign rsp_chan.right_torque = right_ff;
   assign rsp_chan.saturated    = rsp_sat_ff;

   osfc_mac #(
      .SIGNAL_WIDTH   (SIGNAL_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .chunk   (k_ff),
      .coef    (coef),
      .operand (operand),
      .result  (mac_result),
      .sat     (mac_sat)
   );

   osfc_regs #(
      .SIGNAL_WIDTH (SIGNAL_WIDTH)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (regs_ctrl),
      .src        (osfc_pkg::TERMS[pc_ff].src),
      .meas_dist  (req_chan.travelled_distance),
      .meas_pitch (req_chan.pitch_angle),
      .meas_head  (req_chan.heading_angle),
      .wr_data    (mac_result),
      .operand    (operand),
      .int_sat    (int_sat),
      .tq_left    (tq_left),
      .tq_right   (tq_right)
   );

   // clip torques to the 32-bit field
   assign left_ext  = OPW'(tq_left);
   assign right_ext = OPW'(tq_right);

   always_comb begin
      left_clip  = (left_ext > MAX32) || (left_ext < ~MAX32);
      right_clip = (right_ext > MAX32) || (right_ext < ~MAX32);
      priority if (left_ext > MAX32) begin
         left_out = 32'sh7fffffff;
      end else if (left_ext < ~MAX32) begin
         left_out = -32'sh7fffffff - 32'sd1;
      end else begin
         left_out = left_ext[31:0];
      end
      priority if (right_ext > MAX32) begin
         right_out = 32'sh7fffffff;
      end else if (right_ext < ~MAX32) begin
         right_out = -32'sh7fffffff - 32'sd1;
      end else begin
         right_out = right_ext[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         k_ff         <= '0;
         row_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pc_ff    <= '0;
                  k_ff     <= '0;
                  row_ff   <= '0;
                  sat_ff   <= int_sat;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (chunk_top) begin
                  k_ff  <= '0;
                  pc_ff <= PCW'(pc_ff + 1'b1);
                  if (osfc_pkg::TERMS[pc_ff].last) begin
                     state_ff <= S_FLUSH;
                  end
               end else begin
                  k_ff <= KW'(k_ff + 1'b1);
               end
            end
            S_FLUSH: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               sat_ff <= sat_ff | mac_sat;
               if (row_ff == 3'(osfc_pkg::N_ROWS - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  row_ff   <= row_ff + 3'd1;
                  state_ff <= S_MUL;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  left_ff      <= left_out;
                  right_ff     <= right_out;
                  rsp_sat_ff   <= sat_ff | left_clip | right_clip;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_MUL && pc_ff == '0 && row_ff == '0))
      else $error("accepted word did not start the term program");

   a_flush_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |=> (state_ff == S_FIN))
      else $error("drain did not lead to write-back");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (pc_ff < PCW'(osfc_pkg::N_TERMS)))
      else $error("term pointer ran past the program");

   a_done_posts: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_OUT && state_ff == S_IDLE) |-> rsp_valid_ff)
      else $error("finished word not posted to the result register");

endmodule

// File: design/osfc_mac.sv
// Shared multiply-accumulate unit: one coefficient chunk product per cycle while
// issue is set, wide accumulator, round and saturate. Depends on osfc_pkg.
`timescale 1ns / 1ps

module osfc_mac #(
   parameter int SIGNAL_WIDTH   = osfc_pkg::SIGNAL_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = osfc_pkg::COEF_FRAC_BITS_DEF,
   localparam int OPW = osfc_pkg::op_width(SIGNAL_WIDTH),
   localparam int NCH = osfc_pkg::n_chunks(COEF_FRAC_BITS),
   localparam int CPW = osfc_pkg::CHUNK_BITS * NCH + 1,
   localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  osfc_pkg::mac_ctrl_type      ctrl,
   input  logic [KW-1:0]               chunk,
   input  logic signed [CPW-1:0]       coef,
   input  logic signed [OPW-1:0]       operand,
   output logic signed [SIGNAL_WIDTH-1:0] result,
   output logic                        sat
);

   localparam int PW = OPW + osfc_pkg::CHUNK_BITS + 1;
   localparam int AW = OPW + osfc_pkg::CHUNK_BITS * NCH + 8;
   localparam logic signed [AW-1:0] HALF = AW'(64'd1 << (COEF_FRAC_BITS - 1));
   localparam logic signed [AW-1:0] MAXV =
      $signed({{(AW - SIGNAL_WIDTH + 1){1'b0}}, {(SIGNAL_WIDTH - 1){1'b1}}});
   localparam logic signed [SIGNAL_WIDTH-1:0] SMAX =
      $signed({1'b0, {(SIGNAL_WIDTH - 1){1'b1}}});

   logic signed [CPW-1:0] sel;
   logic signed [osfc_pkg::CHUNK_BITS:0] coef_chunk;
   logic signed [PW-1:0]  prod_in;
   logic signed [PW-1:0]  prod_ff;
   logic [KW-1:0]         prod_k_ff;
   logic                  prod_valid_ff;
   logic signed [AW-1:0]  acc_in;
   logic signed [AW-1:0]  acc_ff;
   logic signed [AW-1:0]  rnd;
   logic signed [AW-1:0]  shf;

   assign sel        = coef >>> {chunk, 5'b0};
   assign coef_chunk = $signed({ctrl.top ? sel[osfc_pkg::CHUNK_BITS] : 1'b0,
                                sel[osfc_pkg::CHUNK_BITS-1:0]});
   assign prod_in    = PW'(operand) * PW'(coef_chunk);

   always_comb begin
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + (AW'(prod_ff) <<< {prod_k_ff, 5'b0});
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         prod_valid_ff <= ctrl.issue;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         prod_ff   <= prod_in;
         prod_k_ff <= chunk;
      end
   end

   // round half up, then clip to the signal range
   assign rnd = acc_ff + HALF;
   assign shf = rnd >>> COEF_FRAC_BITS;

   always_comb begin
      priority if (shf > MAXV) begin
         result = SMAX;
         sat    = 1'b1;
      end else if (shf < ~MAXV) begin
         result = ~SMAX;
         sat    = 1'b1;
      end else begin
         result = shf[SIGNAL_WIDTH-1:0];
         sat    = 1'b0;
      end
   end

endmodule

// File: design/osfc_regs.sv
// State file: estimates, integrators, last torques, measurement hold,
// operand select and integrator update. Depends on osfc_pkg.
`timescale 1ns / 1ps

module osfc_regs #(
   parameter int SIGNAL_WIDTH = osfc_pkg::SIGNAL_WIDTH_DEF,
   localparam int OPW = osfc_pkg::op_width(SIGNAL_WIDTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  osfc_pkg::regs_ctrl_type        ctrl,
   input  osfc_pkg::src_type              src,
   input  logic signed [31:0]             meas_dist,
   input  logic signed [31:0]             meas_pitch,
   input  logic signed [31:0]             meas_head,
   input  logic signed [SIGNAL_WIDTH-1:0] wr_data,
   output logic signed [OPW-1:0]          operand,
   output logic                           int_sat,
   output logic signed [SIGNAL_WIDTH-1:0] tq_left,
   output logic signed [SIGNAL_WIDTH-1:0] tq_right
);

   localparam int DW = OPW + 1;
   localparam logic signed [DW-1:0] IMAX =
      $signed({{(DW - SIGNAL_WIDTH + 1){1'b0}}, {(SIGNAL_WIDTH - 1){1'b1}}});

   logic signed [SIGNAL_WIDTH-1:0] est_ff   [6];
   logic signed [SIGNAL_WIDTH-1:0] ne_ff    [6];
   logic signed [SIGNAL_WIDTH-1:0] integ_ff [3];
   logic signed [SIGNAL_WIDTH-1:0] integ_in [3];
   logic signed [SIGNAL_WIDTH-1:0] last_ff  [2];
   logic signed [SIGNAL_WIDTH-1:0] tq_ff    [2];
   logic signed [31:0]             meas_in  [3];
   logic signed [31:0]             meas_ff  [3];
   logic [2:0]                     isat;

   assign meas_in[0] = meas_dist;
   assign meas_in[1] = meas_pitch;
   assign meas_in[2] = meas_head;

   for (genvar i = 0; i < 3; i++) begin : g_int
      logic signed [DW-1:0] diff;
      assign diff = DW'(integ_ff[i]) - DW'(meas_in[i]);
      always_comb begin
         priority if (diff > IMAX) begin
            integ_in[i] = IMAX[SIGNAL_WIDTH-1:0];
            isat[i]     = 1'b1;
         end else if (diff < ~IMAX) begin
            integ_in[i] = ~IMAX[SIGNAL_WIDTH-1:0];
            isat[i]     = 1'b1;
         end else begin
            integ_in[i] = diff[SIGNAL_WIDTH-1:0];
            isat[i]     = 1'b0;
         end
      end
   end

   assign int_sat  = |isat;
   assign tq_left  = tq_ff[0];
   assign tq_right = tq_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) est_ff[i] <= '0;
         for (int i = 0; i < 3; i++) integ_ff[i] <= '0;
         for (int i = 0; i < 2; i++) last_ff[i] <= '0;
      end else begin
         if (ctrl.load) begin
            for (int i = 0; i < 3; i++) integ_ff[i] <= integ_in[i];
         end
         if (ctrl.commit) begin
            for (int i = 0; i < 6; i++) est_ff[i] <= ne_ff[i];
            for (int i = 0; i < 2; i++) last_ff[i] <= tq_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         for (int i = 0; i < 3; i++) meas_ff[i] <= meas_in[i];
      end
      if (ctrl.wr_en) begin
         if (ctrl.wr_row[2:1] == 2'b11) begin
            tq_ff[ctrl.wr_row[0]] <= wr_data;
         end else begin
            ne_ff[ctrl.wr_row] <= wr_data;
         end
      end
   end

   always_comb begin
      unique case (src)
         osfc_pkg::SRC_EST_POS:    operand = OPW'(est_ff[0]);
         osfc_pkg::SRC_EST_VEL:    operand = OPW'(est_ff[1]);
         osfc_pkg::SRC_EST_PITCH:  operand = OPW'(est_ff[2]);
         osfc_pkg::SRC_EST_PRATE:  operand = OPW'(est_ff[3]);
         osfc_pkg::SRC_EST_HEAD:   operand = OPW'(est_ff[4]);
         osfc_pkg::SRC_EST_HRATE:  operand = OPW'(est_ff[5]);
         osfc_pkg::SRC_LAST_LEFT:  operand = OPW'(last_ff[0]);
         osfc_pkg::SRC_LAST_RIGHT: operand = OPW'(last_ff[1]);
         osfc_pkg::SRC_MEAS_DIST:  operand = OPW'(meas_ff[0]);
         osfc_pkg::SRC_MEAS_PITCH: operand = OPW'(meas_ff[1]);
         osfc_pkg::SRC_MEAS_HEAD:  operand = OPW'(meas_ff[2]);
         osfc_pkg::SRC_NEW_POS:    operand = OPW'(ne_ff[0]);
         osfc_pkg::SRC_NEW_VEL:    operand = OPW'(ne_ff[1]);
         osfc_pkg::SRC_NEW_PITCH:  operand = OPW'(ne_ff[2]);
         osfc_pkg::SRC_NEW_PRATE:  operand = OPW'(ne_ff[3]);
         osfc_pkg::SRC_NEW_HEAD:   operand = OPW'(ne_ff[4]);
         osfc_pkg::SRC_NEW_HRATE:  operand = OPW'(ne_ff[5]);
         osfc_pkg::SRC_INT_POS:    operand = OPW'(integ_ff[0]);
         osfc_pkg::SRC_INT_PITCH:  operand = OPW'(integ_ff[1]);
         osfc_pkg::SRC_INT_HEAD:   operand = OPW'(integ_ff[2]);
         default:                  operand = '0;
      endcase
   end

endmodule

// File: bench/tb_observer_state_feedback_controller_core.sv
// Testbench of observer_state_feedback_controller_core: drives measurement words,
// predicts each torque word bit for bit and checks it.
// Depends on osfc_pkg, osfc_req_if, osfc_rsp_if and the core.
`timescale 1ns / 1ps

module tb_observer_state_feedback_controller_core;

   localparam int                 FRAC       = osfc_pkg::COEF_FRAC_BITS_DEF;
   localparam logic [63:0]        SCALE      = 64'd10000000000;
   localparam int                 LIMIT      = 1000000;
   localparam logic signed [31:0] POS_FULL   = 32'sh7FFFFFFF;
   localparam logic signed [31:0] NEG_FULL   = 32'sh80000000;
   localparam logic signed [31:0] ONE_Q16    = 32'sh00010000;

   typedef struct packed {
      logic signed [31:0] left;
      logic signed [31:0] right;
      logic               saturated;
   } torque_word_type;

   class torque_scoreboard;
      logic signed [31:0] est [6];
      logic signed [31:0] integ [3];
      logic signed [31:0] last_left;
      logic signed [31:0] last_right;
      longint             obs_coef [6][11];
      longint             gain_coef [2][9];
      torque_word_type    torque_q [$];
      int                 errors;

      function new();
         longint obs_dec [6][11];
         longint gain_dec [2][9];
         obs_dec = '{
            '{64'sd9846000000, 64'sd1000000, -64'sd72000000, -64'sd36550, 0, 0,
              64'sd522360, 64'sd522360, 64'sd154000000, 64'sd72000000, 0},
            '{-64'sd951000000, 64'sd10000000000, -64'sd4477000000, 64'sd2000000, 0, 0,
              64'sd1085000000, 64'sd1085000000, 64'sd950000000, 64'sd4366000000, 0},
            '{-64'sd73000000, -64'sd36676, 64'sd8833000000, 64'sd9000000, 0, 0,
              64'sd7000000, 64'sd7000000, 64'sd73000000, 64'sd1170000000, 0},
            '{-64'sd5260000000, -64'sd3000000, -64'sd62310000000, 64'sd9968000000, 0, 0,
              64'sd14780000000, 64'sd14780000000, 64'sd5260000000, 64'sd68643000000, 0},
            '{0, 0, 0, 0, 64'sd9146000000, 64'sd10000000,
              -64'sd4000000, 64'sd4000000, 0, 0, 64'sd854000000},
            '{0, 0, 0, 0, -64'sd36000000000, 64'sd9981000000,
              -64'sd8406000000, 64'sd8406000000, 0, 0, 64'sd36000000000}
         };
         gain_dec = '{
            '{64'sd15280000000, 64'sd3149000000, 64'sd13802000000, -64'sd521000000,
              64'sd855000000, 64'sd95000000, 64'sd423170000, -64'sd196700000,
              64'sd40450000},
            '{64'sd15280000000, 64'sd3149000000, 64'sd13802000000, -64'sd521000000,
              -64'sd855000000, -64'sd95000000, 64'sd423170000, -64'sd196700000,
              -64'sd40450000}
         };
         foreach (obs_dec[i, j]) obs_coef[i][j] = coef_of(obs_dec[i][j]);
         foreach (gain_dec[i, j]) gain_coef[i][j] = coef_of(gain_dec[i][j]);
         foreach (est[i]) est[i] = '0;
         foreach (integ[i]) integ[i] = '0;
         last_left  = '0;
         last_right = '0;
         errors     = 0;
      endfunction

      // round to nearest, ties away from zero
      function longint coef_of(input longint d);
         logic [63:0] m;
         logic [63:0] q;
         logic [63:0] r;
         logic [63:0] c;
         m = (d < 0) ? 64'(-d) : 64'(d);
         q = m / SCALE;
         r = m % SCALE;
         c = (q << FRAC) + ((r << FRAC) + SCALE / 2) / SCALE;
         return (d < 0) ? -$signed(c) : $signed(c);
      endfunction

      function logic signed [31:0] round_sat(input logic signed [127:0] acc,
                                             inout bit clipped);
         logic signed [127:0] v;
         v = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
         if (v > 128'sd2147483647) begin
            clipped = 1'b1;
            return POS_FULL;
         end
         if (v < -128'sd2147483648) begin
            clipped = 1'b1;
            return NEG_FULL;
         end
         return v[31:0];
      endfunction

      function logic signed [31:0] clamp32(input longint v, inout bit clipped);
         if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return POS_FULL;
         end
         if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return NEG_FULL;
         end
         return v[31:0];
      endfunction

      function void note_measurement(input logic signed [31:0] distance,
                                     input logic signed [31:0] pitch,
                                     input logic signed [31:0] head);
         logic signed [31:0]  ov [11];
         logic signed [31:0]  ne [6];
         logic signed [31:0]  cv [9];
         logic signed [31:0]  tq [2];
         logic signed [127:0] acc;
         logic signed [127:0] wa;
         logic signed [127:0] wb;
         bit                  clipped;
         torque_word_type     w;
         clipped = 1'b0;
         for (int i = 0; i < 6; i++) ov[i] = est[i];
         ov[6]  = last_left;
         ov[7]  = last_right;
         ov[8]  = distance;
         ov[9]  = pitch;
         ov[10] = head;
         for (int i = 0; i < 6; i++) begin
            acc = '0;
            for (int j = 0; j < 11; j++) begin
               wa  = ov[j];
               wb  = obs_coef[i][j];
               acc = acc + wa * wb;
            end
            ne[i] = round_sat(acc, clipped);
         end
         integ[0] = clamp32(longint'(integ[0]) - longint'(distance), clipped);
         integ[1] = clamp32(longint'(integ[1]) - longint'(pitch), clipped);
         integ[2] = clamp32(longint'(integ[2]) - longint'(head), clipped);
         for (int i = 0; i < 6; i++) cv[i] = ne[i];
         for (int i = 0; i < 3; i++) cv[6 + i] = integ[i];
         for (int i = 0; i < 2; i++) begin
            acc = '0;
            for (int j = 0; j < 9; j++) begin
               wa  = cv[j];
               wb  = gain_coef[i][j];
               acc = acc + wa * wb;
            end
            tq[i] = round_sat(acc, clipped);
         end
         for (int i = 0; i < 6; i++) est[i] = ne[i];
         last_left   = tq[0];
         last_right  = tq[1];
         w.left      = tq[0];
         w.right     = tq[1];
         w.saturated = clipped;
         torque_q.push_back(w);
      endfunction

      function void check_torques(input torque_word_type got);
         torque_word_type want;
         if (torque_q.size() == 0) begin
            $error("torque word with no measurement pending: left %0d right %0d",
                   got.left, got.right);
            errors++;
            return;
         end
         want = torque_q.pop_front();
         if (got.left !== want.left) begin
            $error("left_torque: expected %0d, actual %0d", want.left, got.left);
            errors++;
         end
         if (got.right !== want.right) begin
            $error("right_torque: expected %0d, actual %0d", want.right, got.right);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
            errors++;
         end
      endfunction

      function int pending();
         return torque_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   osfc_req_if req_bus ();
   osfc_rsp_if rsp_bus ();

   observer_state_feedback_controller_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   torque_scoreboard   sb;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 stall_left;
   int                 cycle_count;
   logic signed [31:0] walk_dist;
   logic signed [31:0] walk_pitch;
   logic signed [31:0] walk_head;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      sb                 = new();
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.travelled_distance = '0;
      req_bus.pitch_angle        = '0;
      req_bus.heading_angle      = '0;
      rsp_bus.ready      = 1'b0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      stall_left         = 0;
      cycle_count        = 0;
      walk_dist          = '0;
      walk_pitch         = '0;
      walk_head          = '0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_torques('{rsp_bus.left_torque, rsp_bus.right_torque,
                               rsp_bus.saturated});
         if (req_bus.valid && req_bus.ready)
            sb.note_measurement(req_bus.travelled_distance, req_bus.pitch_angle,
                                req_bus.heading_angle);
      end
   end

   // hold ready low for short stalls, now and then for a long one
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(99) < recv_stall_pct) begin
         stall_left    <= ($urandom_range(7) == 0) ? $urandom_range(0, 150)
                                                   : $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_measurement(input logic signed [31:0] distance,
                                   input logic signed [31:0] pitch,
                                   input logic signed [31:0] head);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 4);
         repeat (gap) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_bus.valid              <= 1'b1;
      req_bus.travelled_distance <= distance;
      req_bus.pitch_angle        <= pitch;
      req_bus.heading_angle      <= head;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic signed [31:0] noise_field();
      int unsigned pick;
      pick = $urandom_range(3);
      if (pick == 0) return $urandom_range(0, 262143) - 131072;
      if (pick == 1) return $urandom_range(0, 33554431) - 16777216;
      if (pick == 2) return $urandom;
      pick = $urandom_range(3);
      if (pick == 0) return POS_FULL;
      if (pick == 1) return NEG_FULL;
      if (pick == 2) return '0;
      return -32'sd1;
   endfunction

   // smooth trajectories mostly, with bursts of noise between them
   task automatic run_random(input int n_items);
      int sent;
      int burst;
      bit smooth;
      sent = 0;
      while (sent < n_items) begin
         smooth = ($urandom_range(9) < 7);
         burst  = smooth ? $urandom_range(4, 16) : $urandom_range(1, 6);
         for (int k = 0; k < burst && sent < n_items; k++) begin
            if (smooth) begin
               walk_dist  = walk_dist + ($urandom_range(0, 4095) - 2048);
               walk_pitch = walk_pitch + ($urandom_range(0, 1023) - 512);
               walk_head  = walk_head + ($urandom_range(0, 2047) - 1024);
               send_measurement(walk_dist, walk_pitch, walk_head);
            end else begin
               send_measurement(noise_field(), noise_field(), noise_field());
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_measurement('0, '0, '0);
      send_measurement(POS_FULL, '0, '0);
      send_measurement(NEG_FULL, '0, '0);
      send_measurement('0, POS_FULL, '0);
      send_measurement('0, NEG_FULL, '0);
      send_measurement('0, '0, POS_FULL);
      send_measurement('0, '0, NEG_FULL);
      send_measurement(POS_FULL, POS_FULL, POS_FULL);
      send_measurement(POS_FULL, POS_FULL, POS_FULL);
      send_measurement(NEG_FULL, NEG_FULL, NEG_FULL);
      send_measurement(NEG_FULL, NEG_FULL, NEG_FULL);
      send_measurement(NEG_FULL, NEG_FULL, NEG_FULL);
      send_measurement(-32'sd1, -32'sd1, -32'sd1);
      send_measurement(32'sd1, 32'sd1, 32'sd1);
      send_measurement(ONE_Q16, -ONE_Q16, ONE_Q16);
      send_measurement(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555);
      send_measurement(32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA);
      repeat (4) send_measurement('0, '0, '0);

      run_random(140);
      send_idle_pct  = 62;
      recv_stall_pct = 0;
      run_random(137);
      send_idle_pct  = 0;
      recv_stall_pct = 62;
      run_random(137);
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      run_random(136);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
design/osfc_pkg.sv
design/osfc_req_if.sv
design/osfc_rsp_if.sv
design/osfc_mac.sv
design/osfc_regs.sv
design/observer_state_feedback_controller_core.sv
bench/tb_observer_state_feedback_controller_core.sv
